### design/jmp_pkg.sv
`default_nettype none
package jmp_pkg;

   // internal signed arithmetic word
   typedef logic signed [63:0] sword_type;

   // operation codes of a request
   localparam logic [1:0] FUNC_RESET = 2'd0;
   localparam logic [1:0] FUNC_P2P   = 2'd1;
   localparam logic [1:0] FUNC_TRACK = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MAX_VEL = 2'd0;
   localparam logic [1:0] CSR_MAX_ACC = 2'd1;
   localparam logic [1:0] CSR_DT      = 2'd2;

   // register reset values
   localparam logic [30:0] MAX_VEL_RST = 31'd16777216;
   localparam logic [31:0] MAX_ACC_RST = 32'd10485760;
   localparam logic [23:0] DT_RST      = 24'd335544;

   // snap tolerances (1e-5 rad, 1e-4 rad/s)
   localparam logic [63:0] SNAP_POS = 64'd168;
   localparam logic [63:0] SNAP_VEL = 64'd1678;

   // serial unit step counts
   localparam logic [6:0] STEPS_DT   = 7'd24;
   localparam logic [6:0] STEPS_AS   = 7'd36;
   localparam logic [6:0] STEPS_ACC  = 7'd32;
   localparam logic [6:0] STEPS_SQRT = 7'd44;
   localparam logic [6:0] STEPS_DIV  = 7'd88;

   // datapath commands
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_RESET_TO,
      OP_PREP,
      OP_AS_TAKE,
      OP_ERR_START,
      OP_SQRT_START,
      OP_DES_P2P,
      OP_RV,
      OP_DES_TRK,
      OP_DV,
      OP_VEL,
      OP_ADVANCE,
      OP_OUTPUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       ok;
      logic       init;
      logic       snap;
      logic       busy;
   } dp_status_type;

   function automatic logic [63:0] mag64(sword_type x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function automatic sword_type clamp64(sword_type x, sword_type lim);
      return x > lim ? lim : (x < -lim ? -lim : x);
   endfunction

endpackage
`default_nettype wire

### design/jmp_ctrl.sv
`default_nettype none
module jmp_ctrl
   import jmp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_PREP, ST_W_AS, ST_AS, ST_W_SQ, ST_ERR, ST_W_ERR,
      ST_SQRT, ST_W_SQRT, ST_DES_P2P, ST_W_DIV, ST_RV, ST_DES_TRK, ST_DV,
      ST_VEL, ST_W_VDT, ST_ADV, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequencing of one request
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.func == FUNC_RESET) begin
               cmd.op   = OP_RESET_TO;
               state_in = ST_OUT;
            end else if ((status.func == FUNC_P2P || status.func == FUNC_TRACK)
                         && status.ok) begin
               if (!status.init) cmd.op = OP_RESET_TO;
               state_in = ST_PREP;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_PREP: begin
            cmd.op   = OP_PREP;
            state_in = (status.func == FUNC_P2P && status.snap) ? ST_OUT : ST_W_AS;
         end
         ST_W_AS:    if (!status.busy) state_in = ST_AS;
         ST_AS: begin
            cmd.op   = OP_AS_TAKE;
            state_in = (status.func == FUNC_P2P) ? ST_W_SQ : ST_W_DIV;
         end
         ST_W_SQ:    if (!status.busy) state_in = ST_ERR;
         ST_ERR: begin
            cmd.op   = OP_ERR_START;
            state_in = ST_W_ERR;
         end
         ST_W_ERR:   if (!status.busy) state_in = ST_SQRT;
         ST_SQRT: begin
            cmd.op   = OP_SQRT_START;
            state_in = ST_W_SQRT;
         end
         ST_W_SQRT:  if (!status.busy) state_in = ST_DES_P2P;
         ST_DES_P2P: begin
            cmd.op   = OP_DES_P2P;
            state_in = ST_DV;
         end
         ST_W_DIV:   if (!status.busy) state_in = ST_RV;
         ST_RV: begin
            cmd.op   = OP_RV;
            state_in = ST_DES_TRK;
         end
         ST_DES_TRK: begin
            cmd.op   = OP_DES_TRK;
            state_in = ST_DV;
         end
         ST_DV: begin
            cmd.op   = OP_DV;
            state_in = ST_VEL;
         end
         ST_VEL: begin
            cmd.op   = OP_VEL;
            state_in = ST_W_VDT;
         end
         ST_W_VDT:   if (!status.busy) state_in = ST_ADV;
         ST_ADV: begin
            cmd.op   = OP_ADVANCE;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_OUTPUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

### design/jmp_dp.sv
`default_nettype none
module jmp_dp
   import jmp_pkg::*;
#(
   parameter int WORD_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_value,
   output logic signed [31:0]      rsp_position_out,
   output logic signed [31:0]      rsp_velocity_out,
   input  wire dp_cmd_type         cmd,
   output dp_status_type           status
);

   localparam sword_type WMAX = (sword_type'(1) <<< (WORD_WIDTH - 1)) - 1;
   localparam sword_type WMIN = -WMAX - 1;
   localparam sword_type OMAX = 64'sd2147483647;
   localparam sword_type OMIN = -64'sd2147483648;

   typedef enum logic [1:0] {U_MUL, U_SQRT, U_DIV} unit_type;

   function automatic logic signed [WORD_WIDTH-1:0] sat_w(sword_type x);
      sword_type y;
      y = x > WMAX ? WMAX : (x < WMIN ? WMIN : x);
      return y[WORD_WIDTH-1:0];
   endfunction

   // configuration
   logic [30:0] vmax_ff;
   logic [31:0] amax_ff;
   logic [23:0] dt_ff;

   // joint state
   logic signed [WORD_WIDTH-1:0] pos_ff, pos_in, lref_ff, lref_in, ref_ff, ref_in;
   logic signed [31:0]           vel_ff, vel_in;
   logic                         init_ff, init_in, track_ff, track_in;
   logic [1:0]                   func_ff, func_in;

   // step intermediates
   logic [35:0]        as_ff, as_in;
   sword_type          err_ff, err_in, dif_ff, dif_in, rv_ff, rv_in, e12_ff, e12_in;
   logic signed [31:0] des_ff, des_in, vnew_ff, vnew_in;
   logic signed [33:0] dv_ff, dv_in;

   // serial multiply / square root / divide unit
   logic [87:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [39:0] mplier_ff, mplier_in;
   logic [45:0] rem_ff, rem_in;
   logic [43:0] root_ff, root_in;
   logic [6:0]  cnt_ff, cnt_in;
   unit_type    umode_ff, umode_in;

   logic signed [31:0] rsp_pos_ff, rsp_pos_in, rsp_vel_ff, rsp_vel_in;

   sword_type   ref64, pos64, lref64, vel64, prev64, err_p2p, vmax64, as64;
   logic [56:0] as_sum;
   logic [35:0] as_next;
   logic [43:0] b_val;
   logic [30:0] des_mag;
   logic [60:0] q_sat;
   logic [63:0] errm, e12m;
   sword_type   dv64, vsum, vcl, step64, p64, trk_des;
   logic [56:0] step_sum;
   logic        guard;
   logic [47:0] rem_t, trial, rem_d;
   logic [24:0] drem, dsub;

   assign ref64   = sword_type'(ref_ff);
   assign pos64   = sword_type'(pos_ff);
   assign lref64  = sword_type'(lref_ff);
   assign vel64   = sword_type'(vel_ff);
   assign prev64  = track_ff ? lref64 : ref64;
   assign err_p2p = ref64 - pos64;
   assign vmax64  = sword_type'({33'd0, vmax_ff});
   assign as64    = sword_type'({28'd0, as_ff});

   // accel step = round(A * dt / 2^20)
   assign as_sum  = {1'b0, acc_ff[55:0]} + 57'd524288;
   assign as_next = as_sum[55:20];

   // braking bound less accel step, then limit
   assign b_val   = root_ff - {8'd0, as_ff};
   assign des_mag = (b_val < {13'd0, vmax_ff}) ? b_val[30:0] : vmax_ff;

   // reference velocity and error gain
   assign q_sat   = (mcand_ff > 88'h1000000000000000) ? 61'h1000000000000000 : mcand_ff[60:0];
   assign errm    = mag64(err_ff);
   assign e12m    = ((errm << 4) + (errm << 3) + errm + 64'd1) >> 1;
   assign trk_des = clamp64(rv_ff + e12_ff, vmax64);

   // velocity update
   assign dv64 = clamp64(sword_type'(des_ff) - vel64, as64);
   assign vsum = vel64 + sword_type'(dv_ff);
   assign vcl  = clamp64(vsum, vmax64);

   // position advance with overshoot guard
   assign step_sum = {1'b0, acc_ff[55:0]} + 57'd8388608;
   assign step64   = vnew_ff < 0 ? -sword_type'({32'd0, step_sum[55:24]})
                                 :  sword_type'({32'd0, step_sum[55:24]});
   assign p64      = pos64 + step64;
   assign guard    = (func_ff == FUNC_P2P) &&
                     ((err_ff > 0 && p64 >= ref64) || (err_ff < 0 && p64 <= ref64));

   // square root and divide step terms
   assign rem_t = {rem_ff, mcand_ff[87:86]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign rem_d = rem_t - trial;
   assign drem  = {rem_ff[23:0], acc_ff[87]};
   assign dsub  = drem - {1'b0, dt_ff};

   assign status.func = func_ff;
   assign status.ok   = (vmax_ff != '0) && (amax_ff != '0) && (dt_ff != '0);
   assign status.init = init_ff;
   assign status.snap = (mag64(err_p2p) < SNAP_POS) && (mag64(vel64) < SNAP_VEL);
   assign status.busy = (cnt_ff != '0);

   assign rsp_position_out = rsp_pos_ff;
   assign rsp_velocity_out = rsp_vel_ff;

   always_comb begin
      pos_in = pos_ff;   lref_in = lref_ff;   ref_in = ref_ff;   vel_in = vel_ff;
      init_in = init_ff; track_in = track_ff; func_in = func_ff;
      as_in = as_ff;     err_in = err_ff;     dif_in = dif_ff;
      rv_in = rv_ff;     e12_in = e12_ff;     des_in = des_ff;
      vnew_in = vnew_ff; dv_in = dv_ff;
      acc_in = acc_ff;   mcand_in = mcand_ff; mplier_in = mplier_ff;
      rem_in = rem_ff;   root_in = root_ff;   cnt_in = cnt_ff; umode_in = umode_ff;
      rsp_pos_in = rsp_pos_ff; rsp_vel_in = rsp_vel_ff;

      // one step of the serial unit
      if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 7'd1;
         case (umode_ff)
            U_MUL: begin
               if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
            U_SQRT: begin
               if (rem_t >= trial) begin
                  rem_in  = rem_d[45:0];
                  root_in = {root_ff[42:0], 1'b1};
               end else begin
                  rem_in  = rem_t[45:0];
                  root_in = {root_ff[42:0], 1'b0};
               end
               mcand_in = mcand_ff << 2;
            end
            U_DIV: begin
               acc_in = acc_ff << 1;
               if (drem >= {1'b0, dt_ff}) begin
                  rem_in   = {22'd0, dsub[23:0]};
                  mcand_in = {mcand_ff[86:0], 1'b1};
               end else begin
                  rem_in   = {22'd0, drem[23:0]};
                  mcand_in = {mcand_ff[86:0], 1'b0};
               end
            end
            default: cnt_in = '0;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            func_in = req_func;
            ref_in  = sat_w(sword_type'(req_value));
         end
         OP_RESET_TO: begin
            pos_in   = ref_ff;
            vel_in   = '0;
            init_in  = 1'b1;
            lref_in  = ref_ff;
            track_in = 1'b0;
         end
         OP_PREP: begin
            if (func_ff == FUNC_P2P) begin
               err_in   = err_p2p;
               lref_in  = ref_ff;
               track_in = 1'b0;
               if (status.snap) begin
                  pos_in = ref_ff;
                  vel_in = '0;
               end
            end else begin
               err_in = prev64 - pos64;
               dif_in = ref64 - prev64;
            end
            // A * dt
            acc_in    = '0;
            mcand_in  = {56'd0, amax_ff};
            mplier_in = {16'd0, dt_ff};
            cnt_in    = STEPS_DT;
            umode_in  = U_MUL;
         end
         OP_AS_TAKE: begin
            as_in = as_next;
            if (func_ff == FUNC_P2P) begin
               // as * as
               acc_in    = '0;
               mcand_in  = {52'd0, as_next};
               mplier_in = {4'd0, as_next};
               cnt_in    = STEPS_AS;
               umode_in  = U_MUL;
            end else begin
               // (|diff| * 2^24 + dt/2) / dt
               acc_in   = {mag64(dif_ff), 24'd0} + {65'd0, dt_ff[23:1]};
               mcand_in = '0;
               rem_in   = '0;
               cnt_in   = STEPS_DIV;
               umode_in = U_DIV;
            end
         end
         OP_ERR_START: begin
            // accumulate |err| * 32 * A on top of as^2
            mcand_in  = {19'd0, mag64(err_ff), 5'd0};
            mplier_in = {8'd0, amax_ff};
            cnt_in    = STEPS_ACC;
            umode_in  = U_MUL;
         end
         OP_SQRT_START: begin
            mcand_in = acc_ff;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = STEPS_SQRT;
            umode_in = U_SQRT;
         end
         OP_DES_P2P: begin
            des_in = err_ff < 0 ? -$signed({1'b0, des_mag}) : $signed({1'b0, des_mag});
         end
         OP_RV: begin
            rv_in  = dif_ff < 0 ? -sword_type'({3'd0, q_sat}) : sword_type'({3'd0, q_sat});
            e12_in = err_ff < 0 ? -sword_type'(e12m) : sword_type'(e12m);
         end
         OP_DES_TRK: des_in = trk_des[31:0];
         OP_DV:      dv_in = dv64[33:0];
         OP_VEL: begin
            vnew_in   = vcl[31:0];
            acc_in    = '0;
            mcand_in  = {24'd0, mag64(vcl)};
            mplier_in = {16'd0, dt_ff};
            cnt_in    = STEPS_DT;
            umode_in  = U_MUL;
         end
         OP_ADVANCE: begin
            pos_in = guard ? ref_ff : sat_w(p64);
            vel_in = guard ? '0 : vnew_ff;
            if (func_ff == FUNC_TRACK) begin
               lref_in  = ref_ff;
               track_in = 1'b1;
            end
         end
         OP_OUTPUT: begin
            rsp_pos_in = pos64 > OMAX ? OMAX[31:0] : (pos64 < OMIN ? OMIN[31:0] : pos64[31:0]);
            rsp_vel_in = vel_ff;
         end
         default: ;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vmax_ff <= MAX_VEL_RST;
         amax_ff <= MAX_ACC_RST;
         dt_ff   <= DT_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAX_VEL: vmax_ff <= csr_data[30:0];
            CSR_MAX_ACC: amax_ff <= csr_data;
            CSR_DT:      dt_ff   <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // joint state and unit control
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         vel_ff   <= '0;
         lref_ff  <= '0;
         init_ff  <= 1'b0;
         track_ff <= 1'b0;
         cnt_ff   <= '0;
         umode_ff <= U_MUL;
      end else begin
         pos_ff   <= pos_in;
         vel_ff   <= vel_in;
         lref_ff  <= lref_in;
         init_ff  <= init_in;
         track_ff <= track_in;
         cnt_ff   <= cnt_in;
         umode_ff <= umode_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ref_ff     <= ref_in;
      func_ff    <= func_in;
      as_ff      <= as_in;
      err_ff     <= err_in;
      dif_ff     <= dif_in;
      rv_ff      <= rv_in;
      e12_ff     <= e12_in;
      des_ff     <= des_in;
      vnew_ff    <= vnew_in;
      dv_ff      <= dv_in;
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
   end

endmodule
`default_nettype wire

### design/joint_motion_profiler_top.sv
`default_nettype none
// Joint motion profiler: one request (func, value) gives one response with the
// new commanded position and velocity. func 0 resets the position, 1 takes a
// point-to-point step (braking bound, velocity/acceleration clamps, snap and
// overshoot guard), 2 takes a tracking step (reference velocity feed-forward
// plus 12.5 x error). Requests are handled one at a time. The steps run on the
// shared bit-serial unit that does the multiplies (24, 36, 32 and 24 steps),
// the 44-step square root and the 88-step divide. A finished response waits
// in an output register, so the next request is taken while it is still
// stalled. Registers are written through csr_write/csr_index/csr_data; the
// user must write them only while no request is in flight, as the block
// itself does not enforce it.
module joint_motion_profiler_top
   import jmp_pkg::*;
#(
   parameter int WORD_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_position_out,
   output logic signed [31:0]      rsp_velocity_out
);

   dp_cmd_type    cmd;
   dp_status_type status;

   jmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   jmp_dp #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_func         (req_func),
      .req_value        (req_value),
      .rsp_position_out (rsp_position_out),
      .rsp_velocity_out (rsp_velocity_out),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
`default_nettype wire
